// ===== rtl/dmn_pkg.sv =====
// ----------------------------------------------------------------------------
// dmn_pkg
// Shared widths, codes and the controller/datapath command and status types.
// ----------------------------------------------------------------------------
package dmn_pkg;

	localparam int MAX_SERVERS_DEF = 8;

	localparam int ACT_W  = 3;
	localparam int SRV_W  = 3;
	localparam int CLK_W  = 32;
	localparam int MSG_W  = 3;
	localparam int CNT_W  = 4;
	localparam int MODE_W = 3;
	localparam int KIND_W = 2;

	localparam logic [CNT_W-1:0] SERVERS_RESET = CNT_W'(8);

	// input actions
	localparam logic [ACT_W-1:0] ACT_CLIENT_REQ    = 3'd0;
	localparam logic [ACT_W-1:0] ACT_CLIENT_REL    = 3'd1;
	localparam logic [ACT_W-1:0] ACT_CLIENT_FINISH = 3'd2;
	localparam logic [ACT_W-1:0] ACT_PEER_REQ      = 3'd3;
	localparam logic [ACT_W-1:0] ACT_PEER_REPLY    = 3'd4;
	localparam logic [ACT_W-1:0] ACT_PEER_LEAVE    = 3'd5;
	localparam logic [ACT_W-1:0] ACT_PEER_GOAWAY   = 3'd6;

	// output messages
	localparam logic [MSG_W-1:0] MSG_REQUEST = 3'd0;
	localparam logic [MSG_W-1:0] MSG_REPLY   = 3'd1;
	localparam logic [MSG_W-1:0] MSG_GRANT   = 3'd2;
	localparam logic [MSG_W-1:0] MSG_LEAVE   = 3'd3;
	localparam logic [MSG_W-1:0] MSG_GOAWAY  = 3'd4;

	// protocol modes
	localparam logic [MODE_W-1:0] MODE_IDLE    = 3'd0;
	localparam logic [MODE_W-1:0] MODE_WAITING = 3'd1;
	localparam logic [MODE_W-1:0] MODE_HELD    = 3'd2;
	localparam logic [MODE_W-1:0] MODE_LEAVING = 3'd3;
	localparam logic [MODE_W-1:0] MODE_DONE    = 3'd4;

	// bitmap scan sources
	localparam logic [KIND_W-1:0] SCAN_BCAST   = 2'd0;
	localparam logic [KIND_W-1:0] SCAN_DREPLY  = 2'd1;
	localparam logic [KIND_W-1:0] SCAN_DGOAWAY = 2'd2;

	// configuration register indexes
	localparam logic REG_OWN_INDEX      = 1'b0;
	localparam logic REG_SERVERS_IN_USE = 1'b1;

	typedef struct packed {
		logic              load;
		logic              set_mode;
		logic [MODE_W-1:0] mode_val;
		logic              bump_clock;
		logic              start_round;
		logic              inc_replies;
		logic              track_clock;
		logic              defer_reply;
		logic              defer_goaway;
		logic              kill_src;
		logic              drop_alive;
		logic              scan_load;
		logic [KIND_W-1:0] scan_kind;
		logic [MSG_W-1:0]  scan_msg;
		logic              scan_step;
		logic              emit;
		logic [MSG_W-1:0]  emit_msg;
		logic              emit_to_own;
		logic              flush;
	} dmn_cmd_t;

	typedef struct packed {
		logic [MODE_W-1:0] mode;
		logic [ACT_W-1:0]  action;
		logic              peer_ok;
		logic              wins;
		logic              need_zero;
		logic              rg_reach;
		logic              scan_empty;
		logic              can_emit;
		logic              can_flush;
		logic              stg_valid;
	} dmn_status_t;

	// effective server count: clip to 1..max_srv
	function automatic logic [CNT_W-1:0] eff_servers(input logic [CNT_W-1:0] siu,
			input int max_srv);
		logic [CNT_W-1:0] n;
		n = siu;
		if (n == '0) n = CNT_W'(1);
		if (int'(n) > max_srv) n = CNT_W'(max_srv);
		return n;
	endfunction

endpackage

// ===== rtl/dmn_in_if.sv =====
// ----------------------------------------------------------------------------
// dmn_in_if
// Input request channel: one received message per request.
// ----------------------------------------------------------------------------
interface dmn_in_if;
	logic                       valid;
	logic                       ready;
	logic [dmn_pkg::ACT_W-1:0]  action;
	logic [dmn_pkg::SRV_W-1:0]  source_server;
	logic [dmn_pkg::CLK_W-1:0]  clock_value;

	modport source(output valid, action, source_server, clock_value, input ready);
	modport sink(input valid, action, source_server, clock_value, output ready);
endinterface

// ===== rtl/dmn_out_if.sv =====
// ----------------------------------------------------------------------------
// dmn_out_if
// Output request channel: one outgoing protocol message per request.
// ----------------------------------------------------------------------------
interface dmn_out_if;
	logic                       valid;
	logic                       ready;
	logic [dmn_pkg::MSG_W-1:0]  message;
	logic [dmn_pkg::SRV_W-1:0]  dest_server;
	logic [dmn_pkg::CLK_W-1:0]  clock_out;
	logic                       last;

	modport source(output valid, message, dest_server, clock_out, last, input ready);
	modport sink(input valid, message, dest_server, clock_out, last, output ready);
endinterface

// ===== rtl/dmn_datapath.sv =====
// ----------------------------------------------------------------------------
// dmn_datapath
// Node state, configuration registers, bitmap scanner and output staging.
// ----------------------------------------------------------------------------
module dmn_datapath #(
	parameter int MAX_SERVERS = dmn_pkg::MAX_SERVERS_DEF
) (
	input  logic                      clk,
	input  logic                      arst_n,
	input  logic [dmn_pkg::ACT_W-1:0] in_action,
	input  logic [dmn_pkg::SRV_W-1:0] in_source,
	input  logic [dmn_pkg::CLK_W-1:0] in_clock,
	input  dmn_pkg::dmn_cmd_t         cmd,
	output dmn_pkg::dmn_status_t      status,
	input  logic                      cfg_we,
	input  logic                      cfg_sel,
	input  logic [31:0]               cfg_wdata,
	output logic [31:0]               cfg_rdata,
	output logic                      out_valid,
	input  logic                      out_ready,
	output logic [dmn_pkg::MSG_W-1:0] out_message,
	output logic [dmn_pkg::SRV_W-1:0] out_dest,
	output logic [dmn_pkg::CLK_W-1:0] out_clock,
	output logic                      out_last
);

	localparam int IDX_W = (MAX_SERVERS > 1) ? $clog2(MAX_SERVERS) : 1;
	localparam logic [dmn_pkg::CNT_W-1:0] RST_N =
		dmn_pkg::eff_servers(dmn_pkg::SERVERS_RESET, MAX_SERVERS);
	localparam logic [MAX_SERVERS-1:0] RST_ALIVE =
		MAX_SERVERS'((64'd1 << RST_N) - 64'd1);

	// configuration
	logic [dmn_pkg::SRV_W-1:0]  own_index_q;
	logic [dmn_pkg::CNT_W-1:0]  siu_q;

	// protocol state
	logic [dmn_pkg::MODE_W-1:0] mode_q;
	logic [dmn_pkg::CLK_W-1:0]  own_clock_q;
	logic [dmn_pkg::CLK_W-1:0]  highest_q;
	logic [dmn_pkg::CNT_W-1:0]  rg_q;
	logic [dmn_pkg::CNT_W-1:0]  rn_q;
	logic [dmn_pkg::CNT_W-1:0]  alive_cnt_q;
	logic [MAX_SERVERS-1:0]     dreply_q;
	logic [MAX_SERVERS-1:0]     dgoaway_q;
	logic [MAX_SERVERS-1:0]     alive_q;

	// captured request
	logic [dmn_pkg::ACT_W-1:0]  action_q;
	logic [dmn_pkg::SRV_W-1:0]  src_q;
	logic [dmn_pkg::CLK_W-1:0]  clkin_q;

	// scanner
	logic [MAX_SERVERS-1:0]     scan_mask_q;
	logic [dmn_pkg::KIND_W-1:0] scan_kind_q;
	logic [dmn_pkg::MSG_W-1:0]  scan_msg_q;

	// staging and output registers
	logic                       stg_valid_q;
	logic [dmn_pkg::MSG_W-1:0]  stg_msg_q;
	logic [dmn_pkg::SRV_W-1:0]  stg_dest_q;
	logic [dmn_pkg::CLK_W-1:0]  stg_clock_q;
	logic                       out_valid_q;
	logic [dmn_pkg::MSG_W-1:0]  out_msg_q;
	logic [dmn_pkg::SRV_W-1:0]  out_dest_q;
	logic [dmn_pkg::CLK_W-1:0]  out_clock_q;
	logic                       out_last_q;

	logic [dmn_pkg::CNT_W-1:0]  n;
	logic [dmn_pkg::CNT_W-1:0]  cfg_n;
	logic [MAX_SERVERS-1:0]     nmask;
	logic [MAX_SERVERS-1:0]     cfg_mask;
	logic [MAX_SERVERS-1:0]     own_oh;
	logic [MAX_SERVERS-1:0]     src_oh;
	logic [MAX_SERVERS-1:0]     scan_low;
	logic [MAX_SERVERS-1:0]     scan_src;
	logic [IDX_W-1:0]           scan_idx;
	logic [dmn_pkg::CNT_W-1:0]  needed;
	logic [dmn_pkg::CNT_W-1:0]  rg_inc;
	logic                       src_alive;
	logic                       out_free;
	logic                       produce;
	logic [dmn_pkg::MSG_W-1:0]  new_msg;
	logic [dmn_pkg::SRV_W-1:0]  new_dest;
	logic                       goaway_step;

	always_comb begin
		n     = dmn_pkg::eff_servers(siu_q, MAX_SERVERS);
		cfg_n = dmn_pkg::eff_servers(cfg_wdata[dmn_pkg::CNT_W-1:0], MAX_SERVERS);
		for (int i = 0; i < MAX_SERVERS; i++) begin
			nmask[i]    = int'(n) > i;
			cfg_mask[i] = int'(cfg_n) > i;
		end
	end

	assign own_oh    = MAX_SERVERS'(1) << own_index_q;
	assign src_oh    = MAX_SERVERS'(1) << src_q;
	assign src_alive = |(alive_q & src_oh);
	assign needed    = (alive_cnt_q != '0) ? alive_cnt_q - 1'b1 : '0;
	assign rg_inc    = rg_q + 1'b1;

	// lowest pending bit of the scan
	assign scan_low = scan_mask_q & (~scan_mask_q + MAX_SERVERS'(1));
	always_comb begin
		scan_idx = '0;
		for (int i = MAX_SERVERS - 1; i >= 0; i--) begin
			if (scan_mask_q[i]) scan_idx = IDX_W'(i);
		end
	end

	always_comb begin
		case (cmd.scan_kind)
			dmn_pkg::SCAN_BCAST:   scan_src = alive_q & ~own_oh & nmask;
			dmn_pkg::SCAN_DREPLY:  scan_src = dreply_q & nmask;
			dmn_pkg::SCAN_DGOAWAY: scan_src = dgoaway_q & alive_q & nmask;
			default:               scan_src = '0;
		endcase
	end

	assign out_free    = !out_valid_q || out_ready;
	assign produce     = cmd.emit || cmd.scan_step;
	assign new_msg     = cmd.scan_step ? scan_msg_q : cmd.emit_msg;
	assign new_dest    = cmd.scan_step ? dmn_pkg::SRV_W'(scan_idx) :
		(cmd.emit_to_own ? own_index_q : src_q);
	assign goaway_step = cmd.scan_step && (scan_kind_q == dmn_pkg::SCAN_DGOAWAY);

	always_comb begin
		status.mode       = mode_q;
		status.action     = action_q;
		status.peer_ok    = (dmn_pkg::CNT_W'(src_q) < n) && (src_q != own_index_q);
		status.wins       = (clkin_q < own_clock_q) ||
			((clkin_q == own_clock_q) && (src_q < own_index_q));
		status.need_zero  = (needed == '0);
		status.rg_reach   = (rg_inc >= rn_q);
		status.scan_empty = (scan_mask_q == '0);
		status.can_emit   = !stg_valid_q || out_free;
		status.can_flush  = out_free;
		status.stg_valid  = stg_valid_q;
	end

	// configuration and protocol state
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			own_index_q <= '0;
			siu_q       <= dmn_pkg::SERVERS_RESET;
			mode_q      <= dmn_pkg::MODE_IDLE;
			own_clock_q <= '0;
			highest_q   <= '0;
			rg_q        <= '0;
			rn_q        <= '0;
			alive_cnt_q <= RST_N;
			dreply_q    <= '0;
			dgoaway_q   <= '0;
			alive_q     <= RST_ALIVE;
			scan_mask_q <= '0;
			scan_kind_q <= dmn_pkg::SCAN_BCAST;
			scan_msg_q  <= dmn_pkg::MSG_REQUEST;
		end else begin
			if (cfg_we) begin
				if (cfg_sel == dmn_pkg::REG_OWN_INDEX) begin
					own_index_q <= cfg_wdata[dmn_pkg::SRV_W-1:0];
				end else begin
					siu_q       <= cfg_wdata[dmn_pkg::CNT_W-1:0];
					alive_cnt_q <= cfg_n;
					alive_q     <= cfg_mask;
				end
			end else begin
				if ((cmd.drop_alive && src_alive) || goaway_step) begin
					if (alive_cnt_q != '0) alive_cnt_q <= alive_cnt_q - 1'b1;
				end
				if (cmd.kill_src) alive_q <= alive_q & ~src_oh;
			end
			if (cmd.set_mode) mode_q <= cmd.mode_val;
			if (cmd.bump_clock) own_clock_q <= highest_q + 1'b1;
			if (cmd.track_clock && (clkin_q > highest_q)) highest_q <= clkin_q;
			if (cmd.start_round) begin
				rg_q <= '0;
				rn_q <= needed;
			end else if (cmd.inc_replies) begin
				rg_q <= rg_inc;
			end
			if (cmd.defer_reply) begin
				dreply_q <= dreply_q | src_oh;
			end else if (cmd.scan_step && (scan_kind_q == dmn_pkg::SCAN_DREPLY)) begin
				dreply_q <= dreply_q & ~scan_low;
			end
			if (cmd.defer_goaway) begin
				dgoaway_q <= dgoaway_q | src_oh;
			end else if (goaway_step) begin
				dgoaway_q <= dgoaway_q & ~scan_low;
			end
			if (cmd.scan_load) begin
				scan_mask_q <= scan_src;
				scan_kind_q <= cmd.scan_kind;
				scan_msg_q  <= cmd.scan_msg;
			end else if (cmd.scan_step) begin
				scan_mask_q <= scan_mask_q & ~scan_low;
			end
		end
	end

	// captured request fields
	always_ff @(posedge clk) begin
		if (cmd.load) begin
			action_q <= in_action;
			src_q    <= in_source;
			clkin_q  <= in_clock;
		end
	end

	// staging: hold the newest result until the next one or the end of the step
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			stg_valid_q <= 1'b0;
			out_valid_q <= 1'b0;
		end else begin
			if (produce) begin
				stg_valid_q <= 1'b1;
			end else if (cmd.flush) begin
				stg_valid_q <= 1'b0;
			end
			if ((produce && stg_valid_q) || cmd.flush) begin
				out_valid_q <= 1'b1;
			end else if (out_ready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (produce) begin
			stg_msg_q   <= new_msg;
			stg_dest_q  <= new_dest;
			stg_clock_q <= own_clock_q;
		end
		if ((produce && stg_valid_q) || cmd.flush) begin
			out_msg_q   <= stg_msg_q;
			out_dest_q  <= stg_dest_q;
			out_clock_q <= stg_clock_q;
			out_last_q  <= cmd.flush;
		end
	end

	assign out_valid   = out_valid_q;
	assign out_message = out_msg_q;
	assign out_dest    = out_dest_q;
	assign out_clock   = out_clock_q;
	assign out_last    = out_last_q;

	assign cfg_rdata = (cfg_sel == dmn_pkg::REG_SERVERS_IN_USE) ?
		32'(siu_q) : 32'(own_index_q);

endmodule

// ===== rtl/dmn_ctrl.sv =====
// ----------------------------------------------------------------------------
// dmn_ctrl
// Sequencer: decodes each request against the mode and steps the datapath.
// ----------------------------------------------------------------------------
module dmn_ctrl (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 in_valid,
	output logic                 in_ready,
	input  dmn_pkg::dmn_status_t status,
	output dmn_pkg::dmn_cmd_t    cmd
);

	localparam logic [2:0] S_IDLE  = 3'd0;
	localparam logic [2:0] S_EXEC  = 3'd1;
	localparam logic [2:0] S_SCAN  = 3'd2;
	localparam logic [2:0] S_GRANT = 3'd3;
	localparam logic [2:0] S_FLUSH = 3'd4;

	logic [2:0] state_q;
	logic [2:0] state_nxt;
	logic       grant_after_q;
	logic       grant_after_nxt;
	logic       finish_after_q;
	logic       finish_after_nxt;
	logic       skip;

	assign in_ready = (state_q == S_IDLE);
	assign skip = (status.mode == dmn_pkg::MODE_DONE) ||
		((status.action >= dmn_pkg::ACT_PEER_REQ) && !status.peer_ok);

	always_comb begin
		cmd              = '0;
		state_nxt        = state_q;
		grant_after_nxt  = grant_after_q;
		finish_after_nxt = finish_after_q;
		case (state_q)
			S_IDLE: begin
				if (in_valid) begin
					cmd.load  = 1'b1;
					state_nxt = S_EXEC;
				end
			end
			S_EXEC: begin
				state_nxt        = S_IDLE;
				grant_after_nxt  = 1'b0;
				finish_after_nxt = 1'b0;
				if (!skip) begin
					case (status.action)
						dmn_pkg::ACT_CLIENT_REQ: begin
							if (status.mode == dmn_pkg::MODE_IDLE) begin
								cmd.bump_clock  = 1'b1;
								cmd.start_round = 1'b1;
								cmd.set_mode    = 1'b1;
								cmd.mode_val    = status.need_zero ?
									dmn_pkg::MODE_HELD : dmn_pkg::MODE_WAITING;
								cmd.scan_load   = 1'b1;
								cmd.scan_kind   = dmn_pkg::SCAN_BCAST;
								cmd.scan_msg    = dmn_pkg::MSG_REQUEST;
								grant_after_nxt = status.need_zero;
								state_nxt       = S_SCAN;
							end
						end
						dmn_pkg::ACT_CLIENT_REL: begin
							if (status.mode == dmn_pkg::MODE_HELD) begin
								cmd.set_mode  = 1'b1;
								cmd.mode_val  = dmn_pkg::MODE_IDLE;
								cmd.scan_load = 1'b1;
								cmd.scan_kind = dmn_pkg::SCAN_DREPLY;
								cmd.scan_msg  = dmn_pkg::MSG_REPLY;
								state_nxt     = S_SCAN;
							end
						end
						dmn_pkg::ACT_CLIENT_FINISH: begin
							if (status.mode == dmn_pkg::MODE_IDLE) begin
								cmd.set_mode     = 1'b1;
								cmd.mode_val     = dmn_pkg::MODE_LEAVING;
								cmd.start_round  = 1'b1;
								cmd.scan_load    = 1'b1;
								cmd.scan_kind    = dmn_pkg::SCAN_BCAST;
								cmd.scan_msg     = dmn_pkg::MSG_LEAVE;
								finish_after_nxt = status.need_zero;
								state_nxt        = S_SCAN;
							end
						end
						dmn_pkg::ACT_PEER_REQ: begin
							if (status.mode == dmn_pkg::MODE_LEAVING) begin
								cmd.emit     = 1'b1;
								cmd.emit_msg = dmn_pkg::MSG_REPLY;
								state_nxt    = S_FLUSH;
							end else begin
								cmd.track_clock = 1'b1;
								if ((status.mode == dmn_pkg::MODE_IDLE) ||
										((status.mode == dmn_pkg::MODE_WAITING) &&
										status.wins)) begin
									cmd.emit     = 1'b1;
									cmd.emit_msg = dmn_pkg::MSG_REPLY;
									state_nxt    = S_FLUSH;
								end else begin
									cmd.defer_reply = 1'b1;
								end
							end
						end
						dmn_pkg::ACT_PEER_REPLY: begin
							if (status.mode == dmn_pkg::MODE_WAITING) begin
								cmd.inc_replies = 1'b1;
								if (status.rg_reach) begin
									cmd.emit        = 1'b1;
									cmd.emit_msg    = dmn_pkg::MSG_GRANT;
									cmd.emit_to_own = 1'b1;
									cmd.set_mode    = 1'b1;
									cmd.mode_val    = dmn_pkg::MODE_HELD;
									state_nxt       = S_FLUSH;
								end
							end
						end
						dmn_pkg::ACT_PEER_LEAVE: begin
							if (status.mode == dmn_pkg::MODE_LEAVING) begin
								if (status.wins) begin
									cmd.emit     = 1'b1;
									cmd.emit_msg = dmn_pkg::MSG_GOAWAY;
									cmd.kill_src = 1'b1;
									state_nxt    = S_FLUSH;
								end else begin
									cmd.defer_goaway = 1'b1;
								end
							end else begin
								cmd.drop_alive = 1'b1;
								cmd.kill_src   = 1'b1;
								cmd.emit       = 1'b1;
								cmd.emit_msg   = dmn_pkg::MSG_GOAWAY;
								state_nxt      = S_FLUSH;
							end
						end
						dmn_pkg::ACT_PEER_GOAWAY: begin
							if (status.mode == dmn_pkg::MODE_LEAVING) begin
								cmd.inc_replies = 1'b1;
								if (status.rg_reach) begin
									cmd.set_mode  = 1'b1;
									cmd.mode_val  = dmn_pkg::MODE_DONE;
									cmd.scan_load = 1'b1;
									cmd.scan_kind = dmn_pkg::SCAN_DGOAWAY;
									cmd.scan_msg  = dmn_pkg::MSG_GOAWAY;
									state_nxt     = S_SCAN;
								end
							end
						end
						default: begin
							state_nxt = S_IDLE;
						end
					endcase
				end
			end
			S_SCAN: begin
				if (status.scan_empty) begin
					if (grant_after_q) begin
						grant_after_nxt = 1'b0;
						state_nxt       = S_GRANT;
					end else if (finish_after_q) begin
						// leave needs no go-aways: send the deferred ones and stop
						finish_after_nxt = 1'b0;
						cmd.set_mode     = 1'b1;
						cmd.mode_val     = dmn_pkg::MODE_DONE;
						cmd.scan_load    = 1'b1;
						cmd.scan_kind    = dmn_pkg::SCAN_DGOAWAY;
						cmd.scan_msg     = dmn_pkg::MSG_GOAWAY;
					end else begin
						state_nxt = status.stg_valid ? S_FLUSH : S_IDLE;
					end
				end else if (status.can_emit) begin
					cmd.scan_step = 1'b1;
				end
			end
			S_GRANT: begin
				if (status.can_emit) begin
					cmd.emit        = 1'b1;
					cmd.emit_msg    = dmn_pkg::MSG_GRANT;
					cmd.emit_to_own = 1'b1;
					state_nxt       = S_FLUSH;
				end
			end
			S_FLUSH: begin
				if (status.can_flush) begin
					cmd.flush = 1'b1;
					state_nxt = S_IDLE;
				end
			end
			default: begin
				state_nxt = S_IDLE;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q        <= S_IDLE;
			grant_after_q  <= 1'b0;
			finish_after_q <= 1'b0;
		end else begin
			state_q        <= state_nxt;
			grant_after_q  <= grant_after_nxt;
			finish_after_q <= finish_after_nxt;
		end
	end

endmodule

// ===== rtl/distributed_mutex_node.sv =====
// ----------------------------------------------------------------------------
// distributed_mutex_node
// One server node of Ricart-Agrawala mutual exclusion with an orderly leave.
// ----------------------------------------------------------------------------
// Usage:
//   in_ch carries one received message per request (client request, release,
//   finish, or a peer request, reply, leave or go-away with source and clock).
//   out_ch carries the messages this node sends; last marks the final one
//   caused by an input. An input with no effect produces nothing on out_ch.
//   The APB port holds own_index (0x0) and servers_in_use (0x4); write them
//   only while no input is in flight. Writing servers_in_use marks all peers
//   alive again.
// Timing:
//   One input at a time; in_ch.ready is high only between inputs. Each input
//   is captured, then decoded, which is all an input with no effect needs. A
//   single direct message is staged at decode and released by a flush step.
//   The bitmap scanner sends one message per cycle while out_ch does not
//   stall, then sees the end of the scan and releases the last message; a
//   grant or the end of a leave is sent after the scan and before release.
//   A message shows on out_ch when the next one is staged or at the flush.
// Reset and stall:
//   arst_n clears the node to idle with all peers alive. When out_ch stalls,
//   the last message holds in the output register and the scanner waits.
// ----------------------------------------------------------------------------
module distributed_mutex_node #(
	parameter int MAX_SERVERS = dmn_pkg::MAX_SERVERS_DEF
) (
	input  logic        clk,
	input  logic        arst_n,
	dmn_in_if.sink      in_ch,
	dmn_out_if.source   out_ch,
	input  logic        psel,
	input  logic        penable,
	input  logic        pwrite,
	input  logic [2:0]  paddr,
	input  logic [31:0] pwdata,
	output logic [31:0] prdata,
	output logic        pready
);

	dmn_pkg::dmn_cmd_t    cmd;
	dmn_pkg::dmn_status_t status;
	logic                 cfg_we;
	logic                 cfg_sel;

	// APB access: registers sit on a 4-byte stride, no wait states
	assign pready  = 1'b1;
	assign cfg_sel = paddr[2];
	assign cfg_we  = psel && penable && pwrite && pready;

	// sequencer: decide what each request does and step the datapath
	dmn_ctrl u_ctrl (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (in_ch.valid),
		.in_ready (in_ch.ready),
		.status   (status),
		.cmd      (cmd)
	);

	// node state, scanner and output registers
	dmn_datapath #(
		.MAX_SERVERS (MAX_SERVERS)
	) u_datapath (
		.clk         (clk),
		.arst_n      (arst_n),
		.in_action   (in_ch.action),
		.in_source   (in_ch.source_server),
		.in_clock    (in_ch.clock_value),
		.cmd         (cmd),
		.status      (status),
		.cfg_we      (cfg_we),
		.cfg_sel     (cfg_sel),
		.cfg_wdata   (pwdata),
		.cfg_rdata   (prdata),
		.out_valid   (out_ch.valid),
		.out_ready   (out_ch.ready),
		.out_message (out_ch.message),
		.out_dest    (out_ch.dest_server),
		.out_clock   (out_ch.clock_out),
		.out_last    (out_ch.last)
	);

endmodule
